/* rtl/assert_macros.svh */
// shared assertion macros, sampled on clk and quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ISE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ise_pkg.sv */
package ise_pkg;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 10;
	localparam int COST_W    = 41;
	localparam int OUT_SUM_W = 26;
	localparam int LEN_W     = 11;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_LO,
		ST_DIFF,
		ST_SQUARE,
		ST_DIVIDE,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic accept;
		logic rd_lo;
		logic diff;
		logic sq_step;
		logic mem_we;
		logic div_load;
		logic div_step;
		logic res_load;
	} ctrl_t;

endpackage

/* rtl/interval_squared_error_engine.sv */
// Interval squared-error engine. Append builds prefix sums and prefix sums of squares of
// the points; a query for [first_index, last_index] returns the interval sum, its length
// and cost = sumsq - floor(sum^2 / length), or the error flag with all other fields zero
// when first_index > last_index or last_index is not below the stored count. One item is
// worked at a time. Append squares |point| in the bit-serial squarer. A bad query goes
// straight to the result state. A good query does its prefix reads on the single store
// read port, forms the differences, squares the sum bit-serially and runs a restoring
// divider that makes one quotient bit per cycle over the 2*SW-bit square, SW = POINT_WIDTH
// + clog2(MAX_POINTS). A query also waits while the previous result still sits unread in
// the output register. Prefix entry zero and the running totals live in flip-flops, so the
// store needs no clearing pass after reset. A finished result waits in the output register
// while the next item is taken in.
module interval_squared_error_engine #(
	parameter int MAX_POINTS  = 1024,
	parameter int POINT_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [ise_pkg::OP_W-1:0]              op,
	input  logic signed [POINT_WIDTH-1:0]         point,
	input  logic [ise_pkg::IDX_W-1:0]             first_index,
	input  logic [ise_pkg::IDX_W-1:0]             last_index,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [ise_pkg::COST_W-1:0]            cost,
	output logic signed [ise_pkg::OUT_SUM_W-1:0]  interval_sum,
	output logic [ise_pkg::LEN_W-1:0]             length,
	output logic                                  error
);
	import ise_pkg::*;

	localparam int AW     = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int SUM_W  = POINT_WIDTH + $clog2(MAX_POINTS);
	localparam int PROD_W = 2 * SUM_W;
	localparam int SQ_W   = COST_W;
	localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
	localparam int DCNT_W = $clog2(PROD_W);

	state_t state_q, state_d;
	ctrl_t  ctrl;

	// prefix store: entry k (k >= 1) sits at address k-1
	logic signed [SUM_W-1:0] sum_mem [MAX_POINTS];
	logic [SQ_W-1:0]         sq_mem  [MAX_POINTS];
	logic signed [SUM_W-1:0] rd_sum_q;
	logic [SQ_W-1:0]         rd_sq_q;
	logic [AW-1:0]           rd_addr;
	logic [AW-1:0]           wr_addr;

	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] run_sum_q;
	logic [SQ_W-1:0]         run_sq_q;

	logic signed [SUM_W-1:0] val_q;
	logic [SQ_W-1:0]         sq_q;
	logic signed [SUM_W-1:0] hi_sum_q;
	logic [SQ_W-1:0]         hi_sq_q;
	logic                    is_query_q;
	logic                    err_q;
	logic [IDX_W-1:0]        first_q;
	logic                    first_zero_q;
	logic [CNT_W-1:0]        len_q;

	logic [SUM_W-1:0]        mplr_q;
	logic [PROD_W-1:0]       mcand_q;
	logic [PROD_W-1:0]       acc_q;
	logic [CNT_W-1:0]        rem_q;
	logic [DCNT_W-1:0]       dcnt_q;

	logic                    out_valid_q;
	logic [COST_W-1:0]       cost_q;
	logic signed [OUT_SUM_W-1:0] isum_q;
	logic [LEN_W-1:0]        len_out_q;
	logic                    err_out_q;

	logic                    count_full;
	logic                    bad_query;
	logic [IDX_W-1:0]        span;
	logic signed [SUM_W-1:0] pt_ext;
	logic [SUM_W-1:0]        pt_mag;
	logic signed [SUM_W-1:0] lo_sum;
	logic [SQ_W-1:0]         lo_sq;
	logic signed [SUM_W-1:0] diff_sum;
	logic [SUM_W-1:0]        diff_mag;
	logic [CNT_W:0]          shifted;
	logic                    trial_ok;
	logic [CNT_W:0]          rem_next;

	assign count_full = (count_q == CNT_W'(MAX_POINTS));
	assign bad_query  = (first_index > last_index) ||
	                    (CMP_W'(last_index) >= CMP_W'(count_q));
	assign span       = last_index - first_index;
	assign pt_ext     = SUM_W'(point);
	assign pt_mag     = pt_ext[SUM_W-1] ? SUM_W'(-pt_ext) : SUM_W'(pt_ext);

	assign lo_sum     = first_zero_q ? '0 : rd_sum_q;
	assign lo_sq      = first_zero_q ? '0 : rd_sq_q;
	assign diff_sum   = hi_sum_q - lo_sum;
	assign diff_mag   = diff_sum[SUM_W-1] ? SUM_W'(-diff_sum) : SUM_W'(diff_sum);

	// restoring division step, one quotient bit per cycle
	assign shifted    = {rem_q, acc_q[PROD_W-1]};
	assign trial_ok   = (shifted >= {1'b0, len_q});
	assign rem_next   = trial_ok ? (shifted - {1'b0, len_q}) : shifted;

	assign rd_addr    = (state_q == ST_READ_LO) ? AW'(first_q - IDX_W'(1)) : AW'(last_index);
	assign wr_addr    = AW'(count_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op)
						OP_APPEND: begin
							if (!count_full) state_d = ST_SQUARE;
						end
						OP_QUERY: begin
							state_d = bad_query ? ST_RESULT : ST_READ_LO;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ_LO: state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_SQUARE;
			ST_SQUARE: begin
				if (mplr_q == '0) state_d = is_query_q ? ST_DIVIDE : ST_IDLE;
			end
			ST_DIVIDE: begin
				if (dcnt_q == '0) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		ctrl          = '0;
		ctrl.in_ready = (state_q == ST_IDLE);
		ctrl.accept   = ctrl.in_ready && in_valid;
		ctrl.rd_lo    = (state_q == ST_READ_LO);
		ctrl.diff     = (state_q == ST_DIFF);
		ctrl.sq_step  = (state_q == ST_SQUARE) && (mplr_q != '0);
		ctrl.mem_we   = (state_q == ST_SQUARE) && (mplr_q == '0) && !is_query_q;
		ctrl.div_load = (state_q == ST_SQUARE) && (mplr_q == '0) && is_query_q;
		ctrl.div_step = (state_q == ST_DIVIDE);
		ctrl.res_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_we) begin
			sum_mem[wr_addr] <= run_sum_q + val_q;
			sq_mem[wr_addr]  <= run_sq_q + SQ_W'(acc_q);
		end
	end

	always_ff @(posedge clk) begin
		rd_sum_q <= sum_mem[rd_addr];
		rd_sq_q  <= sq_mem[rd_addr];
	end

	// running totals double as prefix entry zero's successor chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			run_sum_q <= '0;
			run_sq_q  <= '0;
		end else if (ctrl.accept && op == OP_CLEAR) begin
			count_q   <= '0;
			run_sum_q <= '0;
			run_sq_q  <= '0;
		end else if (ctrl.mem_we) begin
			count_q   <= count_q + CNT_W'(1);
			run_sum_q <= run_sum_q + val_q;
			run_sq_q  <= run_sq_q + SQ_W'(acc_q);
		end
	end

	// datapath: squarer, divider, query operands
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			is_query_q   <= (op == OP_QUERY);
			err_q        <= bad_query;
			first_q      <= first_index;
			first_zero_q <= (first_index == '0);
			len_q        <= CNT_W'(span) + CNT_W'(1);
			val_q        <= pt_ext;
			mplr_q       <= pt_mag;
			mcand_q      <= PROD_W'(pt_mag);
			acc_q        <= '0;
		end
		if (ctrl.rd_lo) begin
			hi_sum_q <= rd_sum_q;
			hi_sq_q  <= rd_sq_q;
		end
		if (ctrl.diff) begin
			val_q   <= diff_sum;
			sq_q    <= hi_sq_q - lo_sq;
			mplr_q  <= diff_mag;
			mcand_q <= PROD_W'(diff_mag);
			acc_q   <= '0;
		end
		if (ctrl.sq_step) begin
			if (mplr_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= mcand_q << 1;
			mplr_q  <= mplr_q >> 1;
		end
		if (ctrl.div_load) begin
			rem_q  <= '0;
			dcnt_q <= DCNT_W'(PROD_W - 1);
		end
		if (ctrl.div_step) begin
			rem_q  <= CNT_W'(rem_next);
			acc_q  <= {acc_q[PROD_W-2:0], trial_ok};
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.res_load) begin
			if (err_q) begin
				cost_q    <= '0;
				isum_q    <= '0;
				len_out_q <= '0;
				err_out_q <= 1'b1;
			end else begin
				// acc_q now holds the quotient
				cost_q    <= sq_q - SQ_W'(acc_q);
				isum_q    <= OUT_SUM_W'(val_q);
				len_out_q <= LEN_W'(len_q);
				err_out_q <= 1'b0;
			end
		end
	end

	assign in_ready     = ctrl.in_ready;
	assign out_valid    = out_valid_q;
	assign cost         = cost_q;
	assign interval_sum = isum_q;
	assign length       = len_out_q;
	assign error        = err_out_q;

endmodule

/* rtl/ise_checker.sv */
`include "assert_macros.svh"

module ise_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_ready,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [ise_pkg::COST_W-1:0]           cost,
	input logic signed [ise_pkg::OUT_SUM_W-1:0] interval_sum,
	input logic [ise_pkg::LEN_W-1:0]            length,
	input logic                                 error
);
	import ise_pkg::*;

	// a result waiting on the sink holds still
	`ISE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cost) && $stable(interval_sum) && $stable(length) && $stable(error), "output changed while stalled")

	// an error result carries nothing else
	`ISE_ASSERT_IMP(a_err_zero, out_valid && error, cost == '0 && interval_sum == '0 && length == '0, "error result with nonzero fields")

	// a good interval covers at least one point
	`ISE_ASSERT_IMP(a_len_nonzero, out_valid && !error, length != '0, "good result with zero length")

	// no result appears in the cycle right after a transfer in
	`ISE_ASSERT_NXT(a_no_instant, in_valid && in_ready, !$rose(out_valid), "result came too early after input transfer")

endmodule

bind interval_squared_error_engine ise_checker u_ise_checker (.*);

/* dv/ise_result_checker.sv */
module ise_result_checker #(
	parameter int MAX_POINTS  = 1024,
	parameter int POINT_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  logic [ise_pkg::OP_W-1:0]             op,
	input  logic signed [POINT_WIDTH-1:0]        point,
	input  logic [ise_pkg::IDX_W-1:0]            first_index,
	input  logic [ise_pkg::IDX_W-1:0]            last_index,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic [ise_pkg::COST_W-1:0]           cost,
	input  logic signed [ise_pkg::OUT_SUM_W-1:0] interval_sum,
	input  logic [ise_pkg::LEN_W-1:0]            length,
	input  logic                                 error,
	input  logic                                 run_done,
	output int                                   fault_count,
	output int                                   answers_due
);
	import ise_pkg::*;

	localparam int PROD_W = 2 * OUT_SUM_W;

	typedef struct {
		logic [COST_W-1:0]           cost;
		logic signed [OUT_SUM_W-1:0] isum;
		logic [LEN_W-1:0]            len;
		logic                        err;
	} answer_t;

	answer_t                     due_answers[$];
	logic signed [OUT_SUM_W-1:0] sum_upto [0:MAX_POINTS];
	logic [COST_W-1:0]           prefix_sq [0:MAX_POINTS];
	int unsigned                 stored;
	bit                          tail_checked;

	// update the prefix stores and queue the answer a query owes
	task automatic absorb_item(input logic [OP_W-1:0] code,
			input logic signed [POINT_WIDTH-1:0] pt,
			input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
		answer_t                     ans;
		logic [POINT_WIDTH-1:0]      pmag;
		logic signed [OUT_SUM_W-1:0] s;
		logic [OUT_SUM_W-1:0]        smag;
		logic [COST_W-1:0]           sq;
		logic [PROD_W-1:0]           quot;
		logic [LEN_W-1:0]            len;
		case (code)
			OP_CLEAR: stored = 0;
			OP_APPEND: begin
				// a full store drops the point
				if (stored < MAX_POINTS) begin
					pmag = pt[POINT_WIDTH-1] ? -pt : pt;
					sum_upto[stored+1] = sum_upto[stored] + OUT_SUM_W'(pt);
					prefix_sq[stored+1] = prefix_sq[stored] +
						COST_W'(pmag) * COST_W'(pmag);
					stored++;
				end
			end
			OP_QUERY: begin
				if (lo > hi || hi >= stored) begin
					ans.cost = '0;
					ans.isum = '0;
					ans.len = '0;
					ans.err = 1'b1;
				end else begin
					s = sum_upto[hi+1] - sum_upto[lo];
					sq = prefix_sq[hi+1] - prefix_sq[lo];
					len = LEN_W'(hi) - LEN_W'(lo) + LEN_W'(1);
					smag = s[OUT_SUM_W-1] ? -s : s;
					quot = (PROD_W'(smag) * PROD_W'(smag)) / PROD_W'(len);
					ans.cost = sq - COST_W'(quot);
					ans.isum = s;
					ans.len = len;
					ans.err = 1'b0;
				end
				due_answers.push_back(ans);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			due_answers.delete();
			sum_upto[0] = '0;
			prefix_sq[0] = '0;
			stored = 0;
			fault_count = 0;
			answers_due = 0;
			tail_checked = 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_answers.size() == 0) begin
					$display("%0t: unexpected result: cost %0d sum %0d length %0d error %0b",
						$time, cost, interval_sum, length, error);
					fault_count++;
				end else begin
					want = due_answers.pop_front();
					if (cost !== want.cost || interval_sum !== want.isum ||
							length !== want.len || error !== want.err) begin
						$display("%0t: result mismatch: expected cost %0d sum %0d length %0d error %0b",
							$time, want.cost, want.isum, want.len, want.err);
						$display("%0t:                    actual cost %0d sum %0d length %0d error %0b",
							$time, cost, interval_sum, length, error);
						fault_count++;
					end
				end
			end
			if (in_valid && in_ready)
				absorb_item(op, point, first_index, last_index);
			answers_due = due_answers.size();
			if (run_done && !tail_checked) begin
				tail_checked = 1'b1;
				if (due_answers.size() != 0) begin
					$display("%0t: %0d expected results never arrived", $time, due_answers.size());
					fault_count++;
				end
			end
		end
	end

endmodule

/* dv/tb_top.sv */
module tb_top;
	import ise_pkg::*;

	localparam int MAX_POINTS  = 1024;
	localparam int POINT_WIDTH = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic signed [POINT_WIDTH-1:0] PT_MAX = 16'sh7fff;
	localparam logic signed [POINT_WIDTH-1:0] PT_MIN = 16'sh8000;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [OP_W-1:0]               op;
	logic signed [POINT_WIDTH-1:0] point;
	logic [IDX_W-1:0]              first_index;
	logic [IDX_W-1:0]              last_index;
	logic                          out_valid;
	logic                          out_ready;
	logic [COST_W-1:0]             cost;
	logic signed [OUT_SUM_W-1:0]   interval_sum;
	logic [LEN_W-1:0]              length;
	logic                          error;
	logic                          run_done;
	logic                          hold_request;

	int fault_count;
	int answers_due;
	int fill_level;
	int send_idle_pct;
	int stall_pct;
	int hold_left;
	int quiet_cycles = 0;

	interval_squared_error_engine #(
		.MAX_POINTS (MAX_POINTS),
		.POINT_WIDTH(POINT_WIDTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.point       (point),
		.first_index (first_index),
		.last_index  (last_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cost        (cost),
		.interval_sum(interval_sum),
		.length      (length),
		.error       (error)
	);

	ise_result_checker #(
		.MAX_POINTS (MAX_POINTS),
		.POINT_WIDTH(POINT_WIDTH)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.point       (point),
		.first_index (first_index),
		.last_index  (last_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cost        (cost),
		.interval_sum(interval_sum),
		.length      (length),
		.error       (error),
		.run_done    (run_done),
		.fault_count (fault_count),
		.answers_due (answers_due)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver: random stalls, plus a long hold-off when requested
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// starts after a falling edge is due, returns at the edge of the transfer
	task automatic send_item(input logic [OP_W-1:0] code,
			input logic signed [POINT_WIDTH-1:0] pt,
			input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		point <= pt;
		first_index <= lo;
		last_index <= hi;
		do
			@(posedge clk);
		while (!in_ready);
		if (code == OP_CLEAR)
			fill_level = 0;
		else if (code == OP_APPEND && fill_level < MAX_POINTS)
			fill_level++;
	endtask

	task automatic pause_sender();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		pause_sender();
		while (answers_due != 0)
			@(negedge clk);
	endtask

	task automatic set_pace(input int idle, input int stall, input bit long_hold);
		pause_sender();
		@(posedge clk);
		send_idle_pct = idle;
		stall_pct = stall;
		hold_request = long_hold;
	endtask

	// query an interval that lies within the stored points, or a random one when the store is empty
	task automatic send_query_inside();
		int unsigned lo;
		int unsigned hi;
		if (fill_level == 0) begin
			hi = $urandom_range(1023);
			lo = $urandom_range(1023);
		end else begin
			hi = $urandom_range(fill_level - 1);
			lo = $urandom_range(hi);
		end
		send_item(OP_QUERY, POINT_WIDTH'($urandom), IDX_W'(lo), IDX_W'(hi));
	endtask

	task automatic pour_random(input int count);
		int                            pick;
		logic signed [POINT_WIDTH-1:0] pt;
		repeat (count) begin
			pick = $urandom_range(99);
			case ($urandom_range(7))
				0: pt = PT_MAX;
				1: pt = PT_MIN;
				2: pt = '0;
				3: pt = -1;
				default: pt = POINT_WIDTH'($urandom);
			endcase
			if (pick < 3)
				send_item(OP_CLEAR, pt, IDX_W'($urandom), IDX_W'($urandom));
			else if (pick < 6)
				send_item(OP_UNUSED, pt, IDX_W'($urandom), IDX_W'($urandom));
			else if (pick < 56)
				send_item(OP_APPEND, pt, IDX_W'($urandom), IDX_W'($urandom));
			else if (pick < 84)
				send_query_inside();
			else
				send_item(OP_QUERY, pt, IDX_W'($urandom), IDX_W'($urandom));
		end
	endtask

	// fill past capacity with extreme points, then query across the whole store
	task automatic fill_store(input bit alternate);
		send_item(OP_CLEAR, '0, '0, '0);
		for (int i = 0; i < MAX_POINTS + 3; i++)
			send_item(OP_APPEND, (alternate && i[0]) ? PT_MAX : PT_MIN,
				IDX_W'($urandom), IDX_W'($urandom));
		send_item(OP_QUERY, '0, 0, 1023);
		send_item(OP_QUERY, '0, 1023, 1023);
		send_item(OP_QUERY, '0, 0, 0);
		send_item(OP_QUERY, '0, 1, 1022);
		repeat (6)
			send_query_inside();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_CLEAR;
		point = '0;
		first_index = '0;
		last_index = '0;
		out_ready = 1'b0;
		run_done = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		fill_level = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// empty store, extremes, bad intervals, unused op, clear
		send_item(OP_QUERY, '0, 0, 0);
		send_item(OP_APPEND, PT_MAX, 0, 0);
		send_item(OP_APPEND, PT_MIN, 0, 0);
		send_item(OP_APPEND, '0, 0, 0);
		send_item(OP_APPEND, -1, 0, 0);
		send_item(OP_APPEND, 1, 0, 0);
		send_item(OP_QUERY, '0, 0, 4);
		send_item(OP_QUERY, '0, 0, 0);
		send_item(OP_QUERY, '0, 1, 1);
		send_item(OP_QUERY, '0, 4, 4);
		send_item(OP_QUERY, '0, 3, 1);
		send_item(OP_QUERY, '0, 2, 5);
		send_item(OP_QUERY, '0, 1023, 1023);
		send_item(OP_QUERY, '0, 0, 1023);
		send_item(OP_UNUSED, PT_MIN, 1023, 1023);
		send_item(OP_CLEAR, PT_MAX, 1023, 341);
		send_item(OP_QUERY, '0, 0, 0);
		repeat (3)
			send_item(OP_APPEND, POINT_WIDTH'($urandom), 0, 0);
		send_item(OP_QUERY, '0, 0, 2);
		send_item(OP_QUERY, '0, 1, 2);

		pour_random(125);

		// receiver holds off while queries keep coming, then sender waits for all results
		set_pace(0, 0, 1'b1);
		repeat (3)
			send_item(OP_APPEND, POINT_WIDTH'($urandom), 0, 0);
		repeat (12)
			send_query_inside();
		wait_drained();

		set_pace(76, 0, 1'b0);
		pour_random(125);
		set_pace(0, 76, 1'b0);
		pour_random(125);
		set_pace(16, 16, 1'b0);
		pour_random(125);
		fill_store(1'b0);
		fill_store(1'b1);

		wait_drained();
		repeat (150) @(negedge clk);
		run_done = 1'b1;
		@(negedge clk);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ise_pkg.sv
rtl/interval_squared_error_engine.sv
rtl/ise_checker.sv
dv/ise_result_checker.sv
dv/tb_top.sv
